@@ rtl/core/b64lw_pkg.sv @@
// Package for the line-wrapping Base64 encoder.
// Holds the payload and queue entry types, character constants and the alphabet lookup.
// It has no dependencies.
package b64lw_pkg;

  localparam int BPL_W = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } dst_item_t;

  typedef struct packed {
    logic [3:0][5:0] sextet;
    logic            pad_third;
    logic            pad_fourth;
    logic            newline;
    logic            last;
  } block_t;

  function automatic logic [7:0] b64_char(input logic [5:0] value);
    logic [7:0] v;
    v = {2'b00, value};
    if (value < 6'd26) begin
      return 8'h41 + v;
    end else if (value < 6'd52) begin
      return 8'h61 + v - 8'd26;
    end else if (value < 6'd62) begin
      return 8'h30 + v - 8'd52;
    end else if (value == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

@@ rtl/core/b64lw_front.sv @@
// Front end of the encoder: gathers bytes into groups of three and counts blocks per line.
// Pushes one finished block description into the queue per group.
// Depends on b64lw_pkg.
module b64lw_front
  import b64lw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [BPL_W-1:0] blocks_per_line,
  input  logic             src_valid,
  input  src_item_t        src_item,
  output logic             src_stall,
  input  logic             queue_full,
  output logic             push,
  output block_t           push_data
);

  logic [15:0]      held_bytes;
  logic [1:0]       group_fill;
  logic [BPL_W-1:0] line_block_count;
  logic [BPL_W-1:0] line_block_count_next;
  logic [BPL_W-1:0] count_inc;
  logic             accept;
  logic             emit;
  logic             newline;
  logic [7:0]       b0, b1, b2;

  assign src_stall = queue_full;
  assign accept = src_valid && !queue_full;
  assign emit = (group_fill == 2'd2) || src_item.last_byte;
  assign push = accept && emit;

  always_comb begin
    b0 = held_bytes[15:8];
    b1 = held_bytes[7:0];
    b2 = src_item.data_byte;
    if (group_fill == 2'd0) begin
      b0 = src_item.data_byte;
      b1 = '0;
      b2 = '0;
    end else if (group_fill == 2'd1) begin
      b1 = src_item.data_byte;
      b2 = '0;
    end
  end

  always_comb begin
    count_inc = line_block_count + 1'b1;
    newline = 1'b0;
    line_block_count_next = '0;
    if (blocks_per_line != '0) begin
      if (count_inc >= blocks_per_line) begin
        newline = 1'b1;
      end else begin
        line_block_count_next = count_inc;
      end
    end
    if (src_item.last_byte) begin
      line_block_count_next = '0;
    end
  end

  always_comb begin
    push_data.sextet[0] = b0[7:2];
    push_data.sextet[1] = {b0[1:0], b1[7:4]};
    push_data.sextet[2] = {b1[3:0], b2[7:6]};
    push_data.sextet[3] = b2[5:0];
    push_data.pad_third = (group_fill == 2'd0);
    push_data.pad_fourth = (group_fill != 2'd2);
    push_data.newline = newline;
    push_data.last = src_item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_fill <= '0;
      line_block_count <= '0;
    end else if (accept) begin
      if (emit) begin
        group_fill <= '0;
        line_block_count <= line_block_count_next;
      end else begin
        group_fill <= group_fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      if (group_fill == 2'd0) begin
        held_bytes[15:8] <= src_item.data_byte;
      end else begin
        held_bytes[7:0] <= src_item.data_byte;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    group_fill != 2'd3)
    else $error("Group fill left its range.");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (push && (push_data.newline || push_data.last || blocks_per_line == '0)) |=>
      (line_block_count == '0))
    else $error("Line block count not cleared at the end of a line.");

endmodule

@@ rtl/core/b64lw_fifo.sv @@
// Short queue of block descriptions between the front and back ends.
// Register array with a pointer pair and a fill count.
// Depends on b64lw_pkg.
module b64lw_fifo
  import b64lw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  block_t push_data,
  input  logic   pop,
  output block_t head,
  output logic   full,
  output logic   empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  block_t           slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("Push into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("Pop from an empty queue.");

endmodule

@@ rtl/core/b64lw_back.sv @@
// Back end of the encoder: takes block descriptions from the queue and, unless stalled,
// sends one character per cycle through a registered output stage. Depends on b64lw_pkg.
module b64lw_back
  import b64lw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  block_t    head,
  input  logic      empty,
  output logic      pop,
  output logic      dst_valid,
  output dst_item_t dst_item,
  input  logic      dst_stall
);

  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_SECOND = 3'd1;
  localparam logic [2:0] POS_THIRD = 3'd2;
  localparam logic [2:0] POS_FOURTH = 3'd3;
  localparam logic [2:0] POS_NEWLINE = 3'd4;

  block_t     cur;
  logic       cur_valid;
  logic [2:0] pos;
  logic       advance;
  logic       at_end;
  dst_item_t  char_next;

  assign advance = cur_valid && (!dst_valid || !dst_stall);
  assign at_end = (pos == (cur.newline ? POS_NEWLINE : POS_FOURTH));
  assign pop = !empty && (!cur_valid || (advance && at_end));

  always_comb begin
    char_next.last_char = 1'b0;
    unique case (pos)
      POS_FIRST:  char_next.out_char = b64_char(cur.sextet[0]);
      POS_SECOND: char_next.out_char = b64_char(cur.sextet[1]);
      POS_THIRD:  char_next.out_char = cur.pad_third ? PAD_CHAR : b64_char(cur.sextet[2]);
      POS_FOURTH: begin
        char_next.out_char = cur.pad_fourth ? PAD_CHAR : b64_char(cur.sextet[3]);
        char_next.last_char = cur.last && !cur.newline;
      end
      POS_NEWLINE: begin
        char_next.out_char = NEWLINE_CHAR;
        char_next.last_char = cur.last;
      end
      default:    char_next.out_char = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      dst_valid <= 1'b0;
      pos <= POS_FIRST;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        pos <= POS_FIRST;
      end else if (advance) begin
        pos <= pos + 1'b1;
        if (at_end) begin
          cur_valid <= 1'b0;
        end
      end
      if (advance) begin
        dst_valid <= 1'b1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance) begin
      dst_item <= char_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (pos <= POS_NEWLINE && (pos != POS_NEWLINE || cur.newline)))
    else $error("Character position beyond the end of its block.");

  a_advance_loads: assert property (@(posedge clk) disable iff (rst)
    advance |=> dst_valid)
    else $error("Character produced but not presented.");

endmodule

@@ rtl/core/base64_line_wrap_encoder_top.sv @@
// Top level of the line-wrapping Base64 encoder.
// Instantiates b64lw_front, b64lw_fifo and b64lw_back; depends on b64lw_pkg.
//
// Usage: source bytes enter on the src channel (src_valid, src_stall, src_item) with
// last_byte set on the final byte of a stream. Characters leave on the dst channel
// (dst_valid, dst_stall, dst_item), one per cycle unless stalled or out of blocks, with
// last_char on the final one. Each group of three bytes, or the final partial group,
// gives four characters with '=' padding; after every blocks_per_line blocks a newline
// follows, none when it is zero. blocks_per_line is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while the block is idle, which it does not
// enforce. A block's first character passes the queue slot, the current-block register
// and the output register after the byte that completes its group is accepted. A byte
// is accepted every cycle while the block queue has room; sustained input is paced by
// the output. Reset clears the open group, the line counter, the queue and
// blocks_per_line. When the receiver stalls, the output character holds, the queue
// fills and then src_stall rises until characters move again.
module base64_line_wrap_encoder_top
  import b64lw_pkg::*;
#(
  parameter int QUEUE_SLOTS = QUEUE_DEPTH
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [BPL_W-1:0] cfg_wr_data,
  input  logic             src_valid,
  input  src_item_t        src_item,
  output logic             src_stall,
  output logic             dst_valid,
  output dst_item_t        dst_item,
  input  logic             dst_stall
);

  logic [BPL_W-1:0] blocks_per_line;
  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_empty;
  block_t           push_data;
  block_t           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_line <= '0;
    end else if (cfg_wr_en) begin
      blocks_per_line <= cfg_wr_data;
    end
  end

  b64lw_front u_front (
    .clk             (clk),
    .rst             (rst),
    .blocks_per_line (blocks_per_line),
    .src_valid       (src_valid),
    .src_item        (src_item),
    .src_stall       (src_stall),
    .queue_full      (queue_full),
    .push            (push),
    .push_data       (push_data)
  );

  b64lw_fifo #(
    .DEPTH (QUEUE_SLOTS)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  b64lw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (queue_empty),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_item  (dst_item),
    .dst_stall (dst_stall)
  );

endmodule
